### rtl/core/shell_command_tokenizer_unit_macros.svh
// Assertion macros for the shell command tokenizer.
// Included by the top level; needs a clk and an active-low rst_n in scope.
`ifndef SHELL_COMMAND_TOKENIZER_UNIT_MACROS_SVH
`define SHELL_COMMAND_TOKENIZER_UNIT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication.
`define SCT_ASSERT_IMPLY(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |-> (post)) \
        else $error(msg);
// Next-cycle implication.
`define SCT_ASSERT_NEXT(lbl, pre, post, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (pre) |=> (post)) \
        else $error(msg);
`else
`define SCT_ASSERT_IMPLY(lbl, pre, post, msg)
`define SCT_ASSERT_NEXT(lbl, pre, post, msg)
`endif
`endif

### rtl/core/sct_pkg.sv
// Types, codes and small decode functions for the shell command tokenizer.
// No dependencies.
`timescale 1ns / 1ps

package sct_pkg;

    // Lexer modes.
    localparam logic [2:0] MODE_IDLE  = 3'd0;
    localparam logic [2:0] MODE_WORD  = 3'd1;
    localparam logic [2:0] MODE_QUOTE = 3'd2;
    localparam logic [2:0] MODE_HELD  = 3'd3;
    localparam logic [2:0] MODE_SKIP  = 3'd4;

    // Event codes.
    localparam logic [1:0] EV_START = 2'd0;
    localparam logic [1:0] EV_CHAR  = 2'd1;
    localparam logic [1:0] EV_DONE  = 2'd2;

    // Token kinds.
    localparam logic [1:0] KIND_WORD   = 2'd0;
    localparam logic [1:0] KIND_STRING = 2'd1;
    localparam logic [1:0] KIND_OP     = 2'd2;

    // Characters.
    localparam logic [7:0] CH_GT     = 8'h3E;
    localparam logic [7:0] CH_LT     = 8'h3C;
    localparam logic [7:0] CH_PIPE   = 8'h7C;
    localparam logic [7:0] CH_AMP    = 8'h26;
    localparam logic [7:0] CH_RPAREN = 8'h29;
    localparam logic [7:0] CH_LPAREN = 8'h28;
    localparam logic [7:0] CH_DQUOTE = 8'h22;
    localparam logic [7:0] CH_SQUOTE = 8'h27;
    localparam logic [7:0] CH_NUL    = 8'h00;

    localparam logic [7:0] TOKEN_LIMIT_RESET = 8'd199;

    // One input byte causes at most four beats.
    localparam int RES_SLOTS = 4;

    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] token_kind;
        logic [7:0] token_char;
        logic [7:0] tokens_seen;
    } result_t;

    typedef struct packed {
        logic [1:0]                last_idx;
        result_t [RES_SLOTS-1:0]   res;
    } bundle_t;

    function automatic result_t make_result(logic [1:0] ev, logic [1:0] kind,
                                            logic [7:0] ch, logic [7:0] count);
        result_t r;
        r.event_kind  = ev;
        r.token_kind  = kind;
        r.token_char  = ch;
        r.tokens_seen = count;
        return r;
    endfunction

    function automatic logic is_blank(logic [7:0] b);
        logic hit;
        case (b) inside
            [8'd9:8'd13], 8'd32: hit = 1'b1;
            default:             hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic is_word_stop(logic [7:0] b);
        logic hit;
        case (b) inside
            CH_GT, CH_LT, CH_PIPE, CH_RPAREN: hit = 1'b1;
            default:                          hit = 1'b0;
        endcase
        return hit;
    endfunction

    // Mode after a token completes: skip the rest of the line at the limit.
    function automatic logic [2:0] end_mode(logic [7:0] total, logic [7:0] limit);
        return (total >= limit) ? MODE_SKIP : MODE_IDLE;
    endfunction

endpackage

### rtl/core/shell_command_tokenizer_unit.sv
// Streaming command-line tokenizer: lexer state, result queue and output port.
// Depends on sct_pkg and shell_command_tokenizer_unit_macros.svh.
`timescale 1ns / 1ps
`include "shell_command_tokenizer_unit_macros.svh"

//  Channel  | Handshake           | Beat contents
//  ---------+---------------------+------------------------------------------------
//  input    | in_valid / in_stall | line_byte, line_end
//  output   | out_valid/out_stall | event_kind, token_kind, token_char,
//           |                     | tokens_seen, run_last
//  config   | cfg_write           | cfg_data (token limit)
//
// An input beat is decoded in the cycle it is accepted; every result beat it causes is
// written as one bundle into a two-entry queue, so one byte per cycle is taken as long
// as each byte causes at most one output beat and out_stall is low. A byte that causes
// several beats holds the output port until all are taken, setting the sustained rate
// once the queue fills. Reset puts the lexer between tokens, clears the count and the
// queue, and sets the token limit to 199. in_stall rises only while the queue is full.

module shell_command_tokenizer_unit
    import sct_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,

    input  logic       cfg_write,
    input  logic [7:0] cfg_data,

    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] line_byte,
    input  logic       line_end,

    output logic       out_valid,
    input  logic       out_stall,
    output logic [1:0] event_kind,
    output logic [1:0] token_kind,
    output logic [7:0] token_char,
    output logic [7:0] tokens_seen,
    output logic       run_last
);

    // Lexer state. The kind of the open token follows from the mode.
    logic [2:0] mode_reg,  mode_next;
    logic       quote_reg, quote_next;
    logic       held_reg,  held_next;
    logic [7:0] total_reg, total_next;
    logic [7:0] limit_reg;

    // Results of the byte being decoded.
    result_t [RES_SLOTS-1:0] res_c;
    logic [2:0]              n_c;
    logic                    from_idle;

    // Result queue: two bundles, plus the beat index inside the head bundle.
    bundle_t    slot_reg [2];
    logic       wr_ptr_reg, rd_ptr_reg;
    logic [1:0] cnt_reg, cnt_next;
    logic [1:0] sub_reg;
    bundle_t    head;
    result_t    head_res;

    logic in_take, out_take, push, pop;

    // Decode one byte against the current mode. Results are packed in order; n_c
    // counts them.
    always_comb
    begin
        mode_next  = mode_reg;
        quote_next = quote_reg;
        held_next  = held_reg;
        total_next = total_reg;
        res_c      = '0;
        n_c        = 3'd0;
        from_idle  = 1'b0;

        if (line_end) begin
            // A held redirect still goes out as an operator; open words and quotes
            // simply end.
            if (mode_reg == MODE_HELD) begin
                total_next = total_next + 8'd1;
                res_c[0] = make_result(EV_START, KIND_OP, CH_NUL, total_next);
                res_c[1] = make_result(EV_CHAR, KIND_OP, held_reg ? CH_LT : CH_GT,
                                       total_next);
                n_c = 3'd2;
            end
            res_c[n_c[1:0]] = make_result(EV_DONE, KIND_WORD, CH_NUL, total_next);
            n_c        = n_c + 3'd1;
            mode_next  = MODE_IDLE;
            quote_next = 1'b0;
            held_next  = 1'b0;
            total_next = 8'd0;
        end else if (line_byte != CH_NUL) begin
            unique case (mode_reg)
                MODE_IDLE:
                begin
                    from_idle = 1'b1;
                end
                MODE_WORD:
                begin
                    if (is_blank(line_byte)) begin
                        mode_next = end_mode(total_next, limit_reg);
                    end else if (is_word_stop(line_byte)) begin
                        // The stop byte starts a new token unless the limit was hit.
                        mode_next = end_mode(total_next, limit_reg);
                        from_idle = (mode_next == MODE_IDLE);
                    end else begin
                        res_c[0] = make_result(EV_CHAR, KIND_WORD, line_byte, total_next);
                        n_c = 3'd1;
                    end
                end
                MODE_QUOTE:
                begin
                    if (line_byte == (quote_reg ? CH_SQUOTE : CH_DQUOTE)) begin
                        mode_next = end_mode(total_next, limit_reg);
                    end else begin
                        res_c[0] = make_result(EV_CHAR, KIND_STRING, line_byte,
                                               total_next);
                        n_c = 3'd1;
                    end
                end
                MODE_HELD:
                begin
                    total_next = total_next + 8'd1;
                    res_c[0] = make_result(EV_START, KIND_OP, CH_NUL, total_next);
                    res_c[1] = make_result(EV_CHAR, KIND_OP, held_reg ? CH_LT : CH_GT,
                                           total_next);
                    n_c = 3'd2;
                    mode_next = end_mode(total_next, limit_reg);
                    if (line_byte == CH_LPAREN) begin
                        res_c[2] = make_result(EV_CHAR, KIND_OP, CH_LPAREN, total_next);
                        n_c = 3'd3;
                    end else begin
                        from_idle = (mode_next == MODE_IDLE);
                    end
                end
                MODE_SKIP:
                begin
                end
                default:
                begin
                    mode_next = MODE_IDLE;
                    from_idle = 1'b1;
                end
            endcase

            // Start of a new token from between tokens.
            if (from_idle) begin
                if (line_byte == CH_GT || line_byte == CH_LT) begin
                    held_next = (line_byte == CH_LT);
                    mode_next = MODE_HELD;
                end else if (line_byte == CH_RPAREN || line_byte == CH_AMP ||
                             line_byte == CH_PIPE) begin
                    total_next = total_next + 8'd1;
                    res_c[n_c[1:0]] = make_result(EV_START, KIND_OP, CH_NUL, total_next);
                    n_c = n_c + 3'd1;
                    res_c[n_c[1:0]] = make_result(EV_CHAR, KIND_OP, line_byte, total_next);
                    n_c = n_c + 3'd1;
                    mode_next = end_mode(total_next, limit_reg);
                end else if (is_blank(line_byte)) begin
                    // Separator only.
                end else if (line_byte == CH_DQUOTE || line_byte == CH_SQUOTE) begin
                    quote_next = (line_byte == CH_SQUOTE);
                    total_next = total_next + 8'd1;
                    res_c[n_c[1:0]] = make_result(EV_START, KIND_STRING, CH_NUL,
                                                  total_next);
                    n_c = n_c + 3'd1;
                    mode_next = MODE_QUOTE;
                end else begin
                    total_next = total_next + 8'd1;
                    res_c[n_c[1:0]] = make_result(EV_START, KIND_WORD, CH_NUL, total_next);
                    n_c = n_c + 3'd1;
                    res_c[n_c[1:0]] = make_result(EV_CHAR, KIND_WORD, line_byte,
                                                  total_next);
                    n_c = n_c + 3'd1;
                    mode_next = MODE_WORD;
                end
            end
        end
    end

    // Handshakes. A byte that causes no beat is still accepted but takes no queue entry.
    assign in_stall = (cnt_reg == 2'd2);
    assign in_take  = in_valid && !in_stall;
    assign push     = in_take && (n_c != 3'd0);

    assign head     = slot_reg[rd_ptr_reg];
    assign head_res = head.res[sub_reg];
    assign out_valid = (cnt_reg != 2'd0);
    assign out_take  = out_valid && !out_stall;
    assign pop       = out_take && (sub_reg == head.last_idx);

    assign event_kind  = head_res.event_kind;
    assign token_kind  = head_res.token_kind;
    assign token_char  = head_res.token_char;
    assign tokens_seen = head_res.tokens_seen;
    assign run_last    = (sub_reg == head.last_idx);

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    // Control state.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            mode_reg   <= MODE_IDLE;
            quote_reg  <= 1'b0;
            held_reg   <= 1'b0;
            total_reg  <= 8'd0;
            limit_reg  <= TOKEN_LIMIT_RESET;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            cnt_reg    <= 2'd0;
            sub_reg    <= 2'd0;
        end else begin
            if (cfg_write) begin
                limit_reg <= cfg_data;
            end
            if (in_take) begin
                mode_reg  <= mode_next;
                quote_reg <= quote_next;
                held_reg  <= held_next;
                total_reg <= total_next;
            end
            if (push) begin
                wr_ptr_reg <= !wr_ptr_reg;
            end
            if (pop) begin
                rd_ptr_reg <= !rd_ptr_reg;
                sub_reg    <= 2'd0;
            end else if (out_take) begin
                sub_reg <= sub_reg + 2'd1;
            end
            cnt_reg <= cnt_next;
        end
    end

    // Queue payload; no reset needed.
    always_ff @(posedge clk)
    begin
        if (push) begin
            slot_reg[wr_ptr_reg].res      <= res_c;
            slot_reg[wr_ptr_reg].last_idx <= 2'(n_c - 3'd1);
        end
    end

    `SCT_ASSERT_IMPLY(a_cnt_range, 1'b1, cnt_reg != 2'd3, "queue count out of range")
    `SCT_ASSERT_IMPLY(a_sub_in_bundle, out_valid, sub_reg <= head.last_idx, "beat index past bundle")
    `SCT_ASSERT_IMPLY(a_done_is_last, out_valid && event_kind == EV_DONE, run_last, "line done not last beat")
    `SCT_ASSERT_NEXT(a_eol_clears, in_take && line_end, mode_reg == MODE_IDLE && total_reg == 8'd0, "line end did not clear lexer")

endmodule

### tb/shell_command_tokenizer_unit_tb.sv
// Testbench for shell_command_tokenizer_unit: directed and random command lines,
// checked beat by beat against a tokenizer model kept inside this file.
// Depends on sct_pkg and the RTL of shell_command_tokenizer_unit only.
`timescale 1ns / 1ps

module shell_command_tokenizer_unit_tb;
    import sct_pkg::*;

    // The run ends as a failure once this many cycles pass with no beat accepted
    // on either channel. The long receiver hold-off is well under this.
    localparam int STALL_LIMIT = 3000;

    // Extra cycles allowed after the last expected beat, so that bytes that cause
    // no beat are fully absorbed before a register write or the end of the run.
    localparam int SETTLE_CYCLES = 8;

    // One input beat: a character of the line, or the line-end marker.
    typedef struct packed {
        logic [7:0] line_byte;
        logic       line_end;
    } line_beat_t;

    // One output beat, as the model predicts it.
    typedef struct packed {
        logic [1:0] event_kind;
        logic [1:0] token_kind;
        logic [7:0] token_char;
        logic [7:0] tokens_seen;
        logic       run_last;
    } token_event_t;

    logic       clk;
    logic       rst_n;
    logic       cfg_write;
    logic [7:0] cfg_data;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] line_byte;
    logic       line_end;
    logic       out_valid;
    logic       out_stall;
    logic [1:0] event_kind;
    logic [1:0] token_kind;
    logic [7:0] token_char;
    logic [7:0] tokens_seen;
    logic       run_last;

    shell_command_tokenizer_unit u_top (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_write   (cfg_write),
        .cfg_data    (cfg_data),
        .in_valid    (in_valid),
        .in_stall    (in_stall),
        .line_byte   (line_byte),
        .line_end    (line_end),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .event_kind  (event_kind),
        .token_kind  (token_kind),
        .token_char  (token_char),
        .tokens_seen (tokens_seen),
        .run_last    (run_last)
    );

    // Bytes waiting to be offered, and the beats the model says must come out.
    line_beat_t   byte_feed[$];
    token_event_t expected_events[$];
    token_event_t step_events[$];

    // Traffic shaping, set per phase by the stimulus process.
    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int hold_left      = 0;

    // Bookkeeping.
    int  error_count  = 0;
    int  fed_total    = 0;
    int  lines_fed    = 0;
    int  in_accepted  = 0;
    int  out_accepted = 0;
    int  quiet_cycles = 0;
    int  limits_used  = 1;
    bit  in_took      = 1'b0;

    // Tokenizer model state. It mirrors the block's reset state.
    logic [2:0] lx_mode   = MODE_IDLE;
    logic       lx_single = 1'b0;
    logic       lx_held_lt = 1'b0;
    logic [7:0] lx_count  = 8'd0;
    logic [7:0] lx_limit  = TOKEN_LIMIT_RESET;
    logic [1:0] lx_kind   = KIND_WORD;

    // ------------------------------------------------------------------
    // Clock: 2 ns period.
    // ------------------------------------------------------------------
    initial clk = 1'b0;
    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    // ------------------------------------------------------------------
    // Tokenizer model. Beats caused by one input beat collect in step_events
    // and move to expected_events once the last of them is marked.
    // ------------------------------------------------------------------
    function automatic bit is_space(logic [7:0] b);
        return (b == 8'd32) || (b >= 8'd9 && b <= 8'd13);
    endfunction

    function automatic void put_event(logic [1:0] ev, logic [1:0] kind, logic [7:0] ch);
        token_event_t e;
        e.event_kind  = ev;
        e.token_kind  = kind;
        e.token_char  = ch;
        e.tokens_seen = lx_count;
        e.run_last    = 1'b0;
        step_events.push_back(e);
    endfunction

    function automatic void open_token(logic [1:0] kind);
        lx_kind  = kind;
        lx_count = lx_count + 8'd1;
        put_event(EV_START, kind, 8'd0);
    endfunction

    // A completed token may use up the limit, after which the line is skipped.
    function automatic void close_token();
        lx_mode = (lx_count >= lx_limit) ? MODE_SKIP : MODE_IDLE;
    endfunction

    function automatic void flush_redirect();
        open_token(KIND_OP);
        put_event(EV_CHAR, KIND_OP, lx_held_lt ? CH_LT : CH_GT);
    endfunction

    function automatic void start_between_tokens(logic [7:0] b);
        if (b == CH_GT || b == CH_LT)
        begin
            lx_held_lt = (b == CH_LT);
            lx_mode    = MODE_HELD;
        end
        else if (b == CH_RPAREN || b == CH_AMP || b == CH_PIPE)
        begin
            open_token(KIND_OP);
            put_event(EV_CHAR, KIND_OP, b);
            close_token();
        end
        else if (is_space(b))
        begin
            // Separator only.
        end
        else if (b == CH_DQUOTE || b == CH_SQUOTE)
        begin
            lx_single = (b == CH_SQUOTE);
            open_token(KIND_STRING);
            lx_mode = MODE_QUOTE;
        end
        else
        begin
            open_token(KIND_WORD);
            put_event(EV_CHAR, KIND_WORD, b);
            lx_mode = MODE_WORD;
        end
    endfunction

    function automatic void tokenize_beat(line_beat_t beat);
        logic [7:0] b;
        b = beat.line_byte;
        step_events.delete();
        if (beat.line_end)
        begin
            if (lx_mode == MODE_HELD)
                flush_redirect();
            put_event(EV_DONE, KIND_WORD, 8'd0);
            lx_mode    = MODE_IDLE;
            lx_single  = 1'b0;
            lx_held_lt = 1'b0;
            lx_count   = 8'd0;
        end
        else if (b != CH_NUL)
        begin
            case (lx_mode)
                MODE_WORD:
                begin
                    if (is_space(b))
                        close_token();
                    else if (b == CH_GT || b == CH_LT || b == CH_PIPE || b == CH_RPAREN)
                    begin
                        close_token();
                        if (lx_mode == MODE_IDLE)
                            start_between_tokens(b);
                    end
                    else
                        put_event(EV_CHAR, lx_kind, b);
                end
                MODE_QUOTE:
                begin
                    if (b == (lx_single ? CH_SQUOTE : CH_DQUOTE))
                        close_token();
                    else
                        put_event(EV_CHAR, lx_kind, b);
                end
                MODE_HELD:
                begin
                    flush_redirect();
                    if (b == CH_LPAREN)
                    begin
                        put_event(EV_CHAR, KIND_OP, CH_LPAREN);
                        close_token();
                    end
                    else
                    begin
                        close_token();
                        if (lx_mode == MODE_IDLE)
                            start_between_tokens(b);
                    end
                end
                MODE_SKIP:
                begin
                    // Rest of the line is dropped.
                end
                default:
                begin
                    lx_mode = MODE_IDLE;
                    start_between_tokens(b);
                end
            endcase
        end
        if (step_events.size() > 0)
            step_events[step_events.size() - 1].run_last = 1'b1;
        foreach (step_events[i])
            expected_events.push_back(step_events[i]);
    endfunction

    // ------------------------------------------------------------------
    // Error reporting.
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        error_count++;
        $display("MISMATCH at %0t: %s", $realtime, msg);
    endtask

    task automatic check_field(string name, logic [7:0] got, logic [7:0] want);
        if (got !== want)
            report_mismatch($sformatf("result beat %0d: %s is %0d, expected %0d",
                                      out_accepted, name, got, want));
    endtask

    // ------------------------------------------------------------------
    // Driver. Inputs change on the falling edge only. A new byte is offered
    // after the previous one was taken, or when nothing is being offered; an
    // offered byte is never withdrawn or changed while the block stalls it.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin : drive_bytes
        line_beat_t nxt;
        if (!rst_n)
            in_valid <= 1'b0;
        else if (!in_valid || in_took)
        begin
            if (byte_feed.size() > 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                nxt = byte_feed.pop_front();
                line_byte <= nxt.line_byte;
                line_end  <= nxt.line_end;
                in_valid  <= 1'b1;
            end
            else
                in_valid <= 1'b0;
        end
    end

    // Receiver side. A pending hold-off keeps stall high for a counted stretch;
    // otherwise stall is drawn at random with the phase's percentage.
    always @(negedge clk)
    begin
        if (!rst_n)
            out_stall <= 1'b0;
        else if (hold_left > 0)
        begin
            out_stall <= 1'b1;
            hold_left--;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    // ------------------------------------------------------------------
    // Monitor. On each rising edge: track register writes, run the model on
    // an accepted byte, then check an accepted result beat against the oldest
    // expectation. The model runs first so that even a same-cycle result
    // would find its expectation waiting.
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin : watch_ports
        token_event_t want;
        bit           busy;
        if (rst_n)
        begin
            busy = 1'b0;
            if (cfg_write)
                lx_limit = cfg_data;
            in_took = in_valid && !in_stall;
            if (in_took)
            begin
                busy = 1'b1;
                in_accepted++;
                tokenize_beat('{line_byte: line_byte, line_end: line_end});
            end
            if (out_valid && !out_stall)
            begin
                busy = 1'b1;
                out_accepted++;
                if (expected_events.size() == 0)
                    report_mismatch($sformatf("result beat %0d arrived with nothing expected",
                                              out_accepted));
                else
                begin
                    want = expected_events.pop_front();
                    check_field("event_kind", 8'(event_kind), 8'(want.event_kind));
                    check_field("token_kind", 8'(token_kind), 8'(want.token_kind));
                    check_field("token_char", token_char, want.token_char);
                    check_field("tokens_seen", tokens_seen, want.tokens_seen);
                    check_field("run_last", 8'(run_last), 8'(want.run_last));
                end
            end
            quiet_cycles = busy ? 0 : quiet_cycles + 1;
            if (quiet_cycles >= STALL_LIMIT)
            begin
                $display("Timeout: %0d cycles with no beat accepted, %0d results outstanding.",
                         quiet_cycles, expected_events.size());
                $display("end of test: mismatches");
                $finish;
            end
        end
    end

    // ------------------------------------------------------------------
    // Stimulus helpers.
    // ------------------------------------------------------------------
    task automatic feed_byte(logic [7:0] b);
        byte_feed.push_back('{line_byte: b, line_end: 1'b0});
        fed_total++;
    endtask

    // The byte that goes with a line end is junk and must be ignored.
    task automatic feed_line_end();
        byte_feed.push_back('{line_byte: 8'($urandom_range(0, 255)), line_end: 1'b1});
        fed_total++;
        lines_fed++;
    endtask

    task automatic feed_text(string s);
        for (int i = 0; i < s.len(); i++)
            feed_byte(s[i]);
    endtask

    // A character that may sit inside a word; the first one must also not
    // open a quote or form an operator on its own.
    function automatic logic [7:0] word_char(bit first);
        logic [7:0] c;
        bit         bad;
        do
        begin
            c   = 8'($urandom_range(1, 255));
            bad = is_space(c) || c == CH_GT || c == CH_LT || c == CH_PIPE ||
                  c == CH_RPAREN;
            if (first)
                bad = bad || c == CH_AMP || c == CH_DQUOTE || c == CH_SQUOTE;
        end
        while (bad);
        return c;
    endfunction

    // One command line built mostly from well-formed tokens with random
    // content, with some random noise bytes and the odd open quote.
    task automatic feed_random_line(int n_tokens);
        logic [7:0] q;
        logic [7:0] c;
        int         n;
        for (int t = 0; t < n_tokens; t++)
        begin
            if ($urandom_range(0, 99) < 8)
                feed_byte(8'($urandom_range(0, 255)));
            else
            begin
                case ($urandom_range(0, 3))
                    0:
                    begin
                        n = $urandom_range(1, 5);
                        feed_byte(word_char(1'b1));
                        for (int i = 1; i < n; i++)
                            feed_byte(word_char(1'b0));
                    end
                    1:
                    begin
                        q = $urandom_range(0, 1) ? CH_SQUOTE : CH_DQUOTE;
                        feed_byte(q);
                        n = $urandom_range(0, 4);
                        for (int i = 0; i < n; i++)
                        begin
                            do
                                c = 8'($urandom_range(0, 255));
                            while (c == q);
                            feed_byte(c);
                        end
                        if ($urandom_range(0, 99) < 85)
                            feed_byte(q);
                    end
                    2:
                    begin
                        case ($urandom_range(0, 2))
                            0:       feed_byte(CH_RPAREN);
                            1:       feed_byte(CH_AMP);
                            default: feed_byte(CH_PIPE);
                        endcase
                    end
                    default:
                    begin
                        feed_byte($urandom_range(0, 1) ? CH_LT : CH_GT);
                        if ($urandom_range(0, 1))
                            feed_byte(CH_LPAREN);
                    end
                endcase
            end
            if ($urandom_range(0, 99) < 60)
                feed_byte($urandom_range(0, 5) == 5 ? 8'd32 : 8'($urandom_range(9, 13)));
        end
        feed_line_end();
    endtask

    // Wait until every queued byte has been taken and every expected beat has
    // come out, then let the block settle.
    task automatic drain();
        while (byte_feed.size() > 0 || in_valid || expected_events.size() > 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    // Register write while the block is idle. Returns just after a rising edge.
    task automatic write_limit(logic [7:0] value);
        @(negedge clk);
        cfg_write <= 1'b1;
        cfg_data  <= value;
        @(negedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        limits_used++;
    endtask

    task automatic set_traffic(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic random_lines(int n_bytes, int token_cap);
        int stop_at;
        stop_at = fed_total + n_bytes;
        while (fed_total < stop_at)
            feed_random_line($urandom_range(1, token_cap));
    endtask

    // ------------------------------------------------------------------
    // Stimulus and end of run.
    // ------------------------------------------------------------------
    initial
    begin
        rst_n     = 1'b0;
        cfg_write = 1'b0;
        cfg_data  = 8'd0;
        in_valid  = 1'b0;
        line_byte = 8'd0;
        line_end  = 1'b0;
        out_stall = 1'b0;
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Phase 1: reset limit, no idling. Directed line first: both two-char
        // operators, all single-char operators, a held redirect ended by a
        // word, a zero byte inside a word, high bytes, a redirect held across
        // a quote, an empty single-quoted string, a line end with a junk byte,
        // a redirect still held at line end, and an open quote at line end.
        set_traffic(0, 0);
        feed_text(">(<()&|>x");
        feed_byte(CH_NUL);
        feed_byte(8'hFF);
        feed_byte(8'h80);
        feed_text("<\"a b\"''");
        feed_line_end();
        feed_text("w>");
        feed_line_end();
        feed_text("'q");
        feed_line_end();
        random_lines(40, 8);
        drain();

        // Phase 2: smallest limit, so most lines are cut after one token.
        write_limit(8'd1);
        set_traffic(74, 0);
        random_lines(50, 6);
        drain();

        // Phase 3: largest limit. The receiver first holds off for a long
        // stretch while bytes keep coming, so the block fills and stalls.
        write_limit(8'd255);
        set_traffic(0, 74);
        hold_left = 300;
        random_lines(50, 8);
        drain();

        // Phase 4: a small random limit with both sides idling now and then.
        write_limit(8'($urandom_range(2, 6)));
        set_traffic(27, 27);
        random_lines(50, 10);
        drain();

        // Phase 5: limit of three with no idling at all.
        write_limit(8'd3);
        set_traffic(0, 0);
        random_lines(50, 8);
        drain();

        $display("Covered %0d input beats in %0d lines and %0d result beats,", in_accepted,
                 lines_fed, out_accepted);
        $display("over %0d token limits (1 and 255 among them) and four traffic patterns.",
                 limits_used);
        if (error_count == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
